FILE: rtl/core/eba_pkg.sv
// Shared types and constants for the egress buffer admission block.
package eba_pkg;

    localparam int CNT_W   = 24;
    localparam int BYTES_W = 16;
    localparam int PORT_W  = 4;
    localparam int QUEUE_W = 3;
    localparam int ALPHA_W = 12;
    localparam int CFG_IDX_W = 3;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QSHARED_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QGUARANTEE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOSSLESS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 3'd5;

    localparam t_cnt                RST_POOL_LIMIT  = 24'd4500000;
    localparam t_cnt                RST_PORT_LIMIT  = 24'd4500000;
    localparam t_cnt                RST_QSHARED_LIM = 24'd4500000;
    localparam t_cnt                RST_QGUARANTEE  = 24'd1501;
    localparam logic                RST_LOSSLESS    = 1'b1;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA       = 12'd64;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [2:0] {
        DROP_NONE  = 3'd0,
        DROP_POOL  = 3'd1,
        DROP_PORT  = 3'd2,
        DROP_QUEUE = 3'd3,
        DROP_DYN   = 3'd4
    } t_drop_reason;

    // Queue that draws on the second shared pool.
    localparam logic [QUEUE_W-1:0] POOL1_QUEUE = 3'd1;

endpackage

FILE: rtl/core/egress_buffer_admission_top.sv
// Egress shared-buffer admission: byte accounting and enqueue admission per queue and port.
//
// One word is taken per cycle while busy is low. Its result is worked out from the stage 1
// registers and put on the o_ ports by the result registers for one cycle, marked by o_done,
// and cannot be stalled. Per-queue and per-port counts live in memories read at acceptance
// and written back from stage 1 in the cycle after; a back-to-back word to the same queue or
// port takes the fresh value from a bypass register. After reset, busy stays high while the
// count memories are swept to zero; configuration writes are taken throughout.
module egress_buffer_admission_top
    import eba_pkg::*;
#(
    parameter int PORTS  = 16,
    parameter int QUEUES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [PORT_W-1:0]    i_port,
    input  logic [QUEUE_W-1:0]   i_queue,
    input  logic [BYTES_W-1:0]   i_packet_bytes,
    output logic                 o_done,
    output logic                 o_admitted,
    output logic [2:0]           o_drop_reason,
    output logic                 o_underflow,
    output logic [CNT_W-1:0]     o_port_bytes_now,
    output logic [CNT_W-1:0]     o_queue_shared_now
);

    localparam int DEPTH = PORTS * QUEUES;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int MUL_W = ALPHA_W + CNT_W;

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // configuration
    t_cnt               r_pool_limit, r_port_limit, r_qs_limit, r_qguar;
    logic               r_lossless;
    logic [ALPHA_W-1:0] r_alpha;

    // memories and pool counts
    t_cnt r_qg_mem [DEPTH];
    t_cnt r_qs_mem [DEPTH];
    t_cnt r_pb_mem [PORTS];
    t_cnt r_pool   [2];

    logic          r_clearing;
    logic [IW-1:0] r_clr;

    // stage 1
    logic          r_v;
    logic          r_op;
    logic          r_inr;
    logic          r_sp;
    logic [BYTES_W-1:0] r_p;
    logic [IW-1:0] r_idx;
    logic [PW-1:0] r_paddr;
    t_cnt          r_g_rd, r_s_rd, r_pb_rd;

    // write-back bypass
    logic          r_lw_v;
    logic [IW-1:0] r_lw_idx;
    logic [PW-1:0] r_lw_paddr;
    t_cnt          r_lw_g, r_lw_s, r_lw_pb;

    // result
    logic          r_done;
    logic          r_adm;
    logic [2:0]    r_reason;
    logic          r_under;
    t_cnt          r_pbn, r_qsn;

    logic          accept;
    logic          a_inr;
    logic [IW-1:0] a_idx;
    logic [PW-1:0] a_paddr;

    assign busy   = r_clearing;
    assign accept = start && !r_clearing;
    assign a_inr  = (32'(i_port) < PORTS) && (32'(i_queue) < QUEUES);
    assign a_idx  = a_inr ? IW'(32'(i_port) * QUEUES + 32'(i_queue)) : '0;
    assign a_paddr = a_inr ? PW'(i_port) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_limit <= RST_POOL_LIMIT;
            r_port_limit <= RST_PORT_LIMIT;
            r_qs_limit   <= RST_QSHARED_LIM;
            r_qguar      <= RST_QGUARANTEE;
            r_lossless   <= RST_LOSSLESS;
            r_alpha      <= RST_ALPHA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POOL_LIMIT:  r_pool_limit <= i_cfg_data;
                REG_PORT_LIMIT:  r_port_limit <= i_cfg_data;
                REG_QSHARED_LIM: r_qs_limit   <= i_cfg_data;
                REG_QGUARANTEE:  r_qguar      <= i_cfg_data;
                REG_LOSSLESS:    r_lossless   <= i_cfg_data[0];
                REG_ALPHA:       r_alpha      <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1 datapath
    t_cnt               g, s, pb, pool;
    t_cnt               n_g, n_s, n_pb, n_pool;
    logic               n_adm, n_under, n_wr;
    t_drop_reason       n_reason;
    logic [CNT_W:0]     sum_pool, sum_port, sum_qs, sum_g, g_plus_s;
    t_cnt               p_ext, free, room, extra;
    logic [MUL_W-1:0]   dyn_rhs, dyn_lhs;

    always_comb begin
        g    = (r_lw_v && r_lw_idx == r_idx) ? r_lw_g : r_g_rd;
        s    = (r_lw_v && r_lw_idx == r_idx) ? r_lw_s : r_s_rd;
        pb   = (r_lw_v && r_lw_paddr == r_paddr) ? r_lw_pb : r_pb_rd;
        pool = r_pool[r_sp];
        p_ext = CNT_W'(r_p);

        sum_pool = {1'b0, pool} + {1'b0, p_ext};
        sum_port = {1'b0, pb} + {1'b0, p_ext};
        sum_qs   = {1'b0, s} + {1'b0, p_ext};
        sum_g    = {1'b0, g} + {1'b0, p_ext};
        g_plus_s = {1'b0, g} + {1'b0, s};
        free     = r_pool_limit - pool;
        dyn_rhs  = MUL_W'(r_alpha) * MUL_W'(free);
        dyn_lhs  = MUL_W'({sum_qs, 8'd0});
        room     = (r_qguar > g) ? r_qguar - g : '0;
        extra    = p_ext - room;

        n_g = g; n_s = s; n_pb = pb; n_pool = pool;
        n_adm = 1'b1; n_under = 1'b0; n_reason = DROP_NONE;
        n_wr = r_v && r_inr;

        if (!r_inr) begin
            n_adm = (r_op == OP_DEQ);
            n_s   = '0;
            n_pb  = '0;
        end else if (r_op == OP_ENQ) begin
            if (sum_pool > {1'b0, r_pool_limit})
                n_reason = DROP_POOL;
            else if (sum_port > {1'b0, r_port_limit})
                n_reason = DROP_PORT;
            else if (sum_qs > {1'b0, r_qs_limit})
                n_reason = DROP_QUEUE;
            else if (!r_lossless && dyn_lhs > dyn_rhs)
                n_reason = DROP_DYN;

            if (n_reason != DROP_NONE) begin
                n_adm = 1'b0;
            end else if (sum_g < {1'b0, r_qguar}) begin
                n_g  = sum_g[CNT_W-1:0];
                n_pb = sat_add(pb, p_ext);
            end else begin
                if (room != '0)
                    n_g = r_qguar;
                n_s    = sat_add(s, extra);
                n_pb   = sat_add(pb, p_ext);
                n_pool = sat_add(pool, extra);
            end
        end else begin
            if (pb < p_ext) begin
                n_pb = '0; n_under = 1'b1;
            end else begin
                n_pb = pb - p_ext;
            end
            if (g < r_qguar) begin
                if (g < p_ext) begin
                    n_g = '0; n_under = 1'b1;
                end else begin
                    n_g = g - p_ext;
                end
            end else if (g == r_qguar && s < p_ext) begin
                if (g_plus_s < {1'b0, p_ext}) begin
                    n_g = '0; n_under = 1'b1;
                end else begin
                    n_g = CNT_W'(g_plus_s - {1'b0, p_ext});
                end
                if (pool < s) begin
                    n_pool = '0; n_under = 1'b1;
                end else begin
                    n_pool = pool - s;
                end
                n_s = '0;
            end else begin
                if (s < p_ext) begin
                    n_s = '0; n_under = 1'b1;
                end else begin
                    n_s = s - p_ext;
                end
                if (pool < p_ext) begin
                    n_pool = '0; n_under = 1'b1;
                end else begin
                    n_pool = pool - p_ext;
                end
            end
        end
    end

    // count memories: sweep after reset, write-back from stage 1, read at acceptance
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_qg_mem[r_clr] <= '0;
            r_qs_mem[r_clr] <= '0;
            if (32'(r_clr) < PORTS)
                r_pb_mem[PW'(r_clr)] <= '0;
        end else if (n_wr) begin
            r_qg_mem[r_idx]   <= n_g;
            r_qs_mem[r_idx]   <= n_s;
            r_pb_mem[r_paddr] <= n_pb;
        end
        r_g_rd  <= r_qg_mem[a_idx];
        r_s_rd  <= r_qs_mem[a_idx];
        r_pb_rd <= r_pb_mem[a_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_v        <= 1'b0;
            r_lw_v     <= 1'b0;
            r_done     <= 1'b0;
            r_pool[0]  <= '0;
            r_pool[1]  <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + IW'(1);
                if (32'(r_clr) == DEPTH - 1)
                    r_clearing <= 1'b0;
            end
            r_v    <= accept;
            r_lw_v <= n_wr;
            r_done <= r_v;
            if (n_wr)
                r_pool[r_sp] <= n_pool;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_inr   <= a_inr;
            r_sp    <= (i_queue == POOL1_QUEUE);
            r_p     <= i_packet_bytes;
            r_idx   <= a_idx;
            r_paddr <= a_paddr;
        end
        r_lw_idx   <= r_idx;
        r_lw_paddr <= r_paddr;
        r_lw_g     <= n_g;
        r_lw_s     <= n_s;
        r_lw_pb    <= n_pb;
        r_adm      <= n_adm;
        r_reason   <= n_reason;
        r_under    <= n_under;
        r_pbn      <= n_pb;
        r_qsn      <= n_s;
    end

    assign o_done             = r_done;
    assign o_admitted         = r_adm;
    assign o_drop_reason      = r_reason;
    assign o_underflow        = r_under;
    assign o_port_bytes_now   = r_pbn;
    assign o_queue_shared_now = r_qsn;

endmodule

FILE: tb/egress_buffer_admission_top_tb.sv
// Self-checking testbench for egress_buffer_admission_top: directed table, then random traffic.
module egress_buffer_admission_top_tb
    import eba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PORTS  = 16;
    localparam int QUEUES = 8;
    localparam int SLOTS  = PORTS * QUEUES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS = 25;

    typedef struct packed {
        logic         admitted;
        t_drop_reason reason;
        logic         underflow;
        t_cnt         port_now;
        t_cnt         shared_now;
    } t_verdict;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        t_cnt                 reg_val;
        logic                 op;
        logic [PORT_W-1:0]    port;
        logic [QUEUE_W-1:0]   queue;
        logic [BYTES_W-1:0]   bytes;
        logic                 typed;
        t_verdict             want;
    } t_dir_row;

    localparam t_verdict FROM_MODEL = '0;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CNT_W-1:0]     i_cfg_data;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [PORT_W-1:0]    i_port;
    logic [QUEUE_W-1:0]   i_queue;
    logic [BYTES_W-1:0]   i_packet_bytes;
    logic                 o_done;
    logic                 o_admitted;
    logic [2:0]           o_drop_reason;
    logic                 o_underflow;
    logic [CNT_W-1:0]     o_port_bytes_now;
    logic [CNT_W-1:0]     o_queue_shared_now;

    egress_buffer_admission_top #(
        .PORTS  (PORTS),
        .QUEUES (QUEUES)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_port             (i_port),
        .i_queue            (i_queue),
        .i_packet_bytes     (i_packet_bytes),
        .o_done             (o_done),
        .o_admitted         (o_admitted),
        .o_drop_reason      (o_drop_reason),
        .o_underflow        (o_underflow),
        .o_port_bytes_now   (o_port_bytes_now),
        .o_queue_shared_now (o_queue_shared_now)
    );

    always #5 i_clk = ~i_clk;

    // shadow configuration
    t_cnt               lim_pool;
    t_cnt               lim_port;
    t_cnt               lim_qshared;
    t_cnt               guar_bytes;
    logic               lossless_on;
    logic [ALPHA_W-1:0] alpha_q8;

    // shadow byte counts
    t_cnt guar_cnt [SLOTS];
    t_cnt shr_cnt  [SLOTS];
    t_cnt port_cnt [PORTS];
    t_cnt pool_cnt [2];

    t_verdict           verdicts_due [$];
    logic [BYTES_W-1:0] held_pkts [SLOTS][$];
    int                 sender_idle_pct;
    int unsigned        mismatches;
    int unsigned        cycles;
    t_verdict           seen;
    t_verdict           due;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{1'b0, '0, '0, OP_ENQ, 4'd0, 3'd0, 16'd0, 1'b1,
          '{1'b1, DROP_NONE, 1'b0, 24'd0, 24'd0}},
        '{1'b0, '0, '0, OP_ENQ, 4'd15, 3'd7, 16'd65535, 1'b1,
          '{1'b1, DROP_NONE, 1'b0, 24'd65535, 24'd64034}},
        '{1'b0, '0, '0, OP_DEQ, 4'd3, 3'd2, 16'd100, 1'b1,
          '{1'b1, DROP_NONE, 1'b1, 24'd0, 24'd0}},
        '{1'b0, '0, '0, OP_DEQ, 4'd15, 3'd7, 16'd65535, 1'b0, FROM_MODEL},
        '{1'b1, REG_POOL_LIMIT, 24'd3000, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b1, REG_PORT_LIMIT, 24'd5000, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b1, REG_QSHARED_LIM, 24'd2000, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b1, REG_QGUARANTEE, 24'd1000, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b1, REG_LOSSLESS, 24'd0, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b1, REG_ALPHA, 24'd256, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_ENQ, 4'd1, 3'd1, 16'd4000, 1'b1,
          '{1'b0, DROP_POOL, 1'b0, 24'd0, 24'd0}},
        '{1'b0, '0, '0, OP_ENQ, 4'd1, 3'd1, 16'd2500, 1'b1,
          '{1'b0, DROP_QUEUE, 1'b0, 24'd0, 24'd0}},
        '{1'b0, '0, '0, OP_ENQ, 4'd1, 3'd1, 16'd1500, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_ENQ, 4'd1, 3'd1, 16'd1200, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_ENQ, 4'd1, 3'd1, 16'd300, 1'b1,
          '{1'b0, DROP_DYN, 1'b0, 24'd2700, 24'd1700}},
        '{1'b0, '0, '0, OP_ENQ, 4'd1, 3'd2, 16'd2500, 1'b1,
          '{1'b0, DROP_PORT, 1'b0, 24'd2700, 24'd0}},
        '{1'b0, '0, '0, OP_DEQ, 4'd1, 3'd1, 16'd200, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_DEQ, 4'd1, 3'd1, 16'd1800, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_DEQ, 4'd1, 3'd1, 16'd900, 1'b1,
          '{1'b1, DROP_NONE, 1'b1, 24'd0, 24'd0}},
        '{1'b0, '0, '0, OP_ENQ, 4'd2, 3'd3, 16'd999, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_ENQ, 4'd2, 3'd3, 16'd200, 1'b0, FROM_MODEL},
        '{1'b1, REG_QGUARANTEE, 24'd0, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b1, REG_ALPHA, 24'd4095, OP_ENQ, '0, '0, '0, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_DEQ, 4'd2, 3'd3, 16'd100, 1'b0, FROM_MODEL},
        '{1'b0, '0, '0, OP_ENQ, 4'd15, 3'd0, 16'd65535, 1'b1,
          '{1'b0, DROP_POOL, 1'b0, 24'd0, 24'd0}}
    };

    function automatic t_cnt sat_add24(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endfunction

    function automatic t_cnt sat_sub24(input logic [CNT_W:0] a, input t_cnt b,
                                       inout logic under);
        logic [CNT_W:0] diff;
        if (a < {1'b0, b}) begin
            under = 1'b1;
            return '0;
        end
        diff = a - {1'b0, b};
        return diff[CNT_W-1:0];
    endfunction

    // admission decision and byte accounting for one word
    function automatic t_verdict predict_admission(input logic op,
            input logic [PORT_W-1:0] port, input logic [QUEUE_W-1:0] queue,
            input logic [BYTES_W-1:0] bytes);
        logic [PORT_W+QUEUE_W-1:0] slot;
        logic     sel;
        t_cnt     g;
        t_cnt     s;
        t_cnt     p;
        t_cnt     room;
        t_cnt     extra;
        logic     under;
        t_verdict v;
        slot = {port, queue};
        sel = (queue == POOL1_QUEUE);
        g = guar_cnt[slot];
        s = shr_cnt[slot];
        p = {8'b0, bytes};
        under = 1'b0;
        v = FROM_MODEL;
        v.admitted = 1'b1;
        v.reason = DROP_NONE;
        if (op == OP_ENQ) begin
            if (64'(pool_cnt[sel]) + 64'(p) > 64'(lim_pool)) begin
                v.reason = DROP_POOL;
            end else if (64'(port_cnt[port]) + 64'(p) > 64'(lim_port)) begin
                v.reason = DROP_PORT;
            end else if (64'(s) + 64'(p) > 64'(lim_qshared)) begin
                v.reason = DROP_QUEUE;
            end else if (!lossless_on && (64'(s) + 64'(p)) * 64'd256 >
                         64'(alpha_q8) * 64'(lim_pool - pool_cnt[sel])) begin
                v.reason = DROP_DYN;
            end
            if (v.reason != DROP_NONE) begin
                v.admitted = 1'b0;
            end else if (64'(g) + 64'(p) < 64'(guar_bytes)) begin
                guar_cnt[slot] = g + p;
                port_cnt[port] = sat_add24(port_cnt[port], p);
            end else begin
                room = (guar_bytes > g) ? guar_bytes - g : '0;
                extra = p - room;
                if (room != '0) guar_cnt[slot] = guar_bytes;
                shr_cnt[slot] = sat_add24(s, extra);
                port_cnt[port] = sat_add24(port_cnt[port], p);
                pool_cnt[sel] = sat_add24(pool_cnt[sel], extra);
            end
        end else begin
            if (g < guar_bytes) begin
                guar_cnt[slot] = sat_sub24({1'b0, g}, p, under);
                port_cnt[port] = sat_sub24({1'b0, port_cnt[port]}, p, under);
            end else if (g == guar_bytes && s < p) begin
                guar_cnt[slot] = sat_sub24({1'b0, g} + {1'b0, s}, p, under);
                pool_cnt[sel] = sat_sub24({1'b0, pool_cnt[sel]}, s, under);
                shr_cnt[slot] = '0;
                port_cnt[port] = sat_sub24({1'b0, port_cnt[port]}, p, under);
            end else begin
                shr_cnt[slot] = sat_sub24({1'b0, s}, p, under);
                port_cnt[port] = sat_sub24({1'b0, port_cnt[port]}, p, under);
                pool_cnt[sel] = sat_sub24({1'b0, pool_cnt[sel]}, p, under);
            end
        end
        v.underflow = under;
        v.port_now = port_cnt[port];
        v.shared_now = shr_cnt[slot];
        return v;
    endfunction

    // called at a falling edge; returns at a falling edge with start and the word still driven
    task automatic send_word(input logic op, input logic [PORT_W-1:0] port,
                             input logic [QUEUE_W-1:0] queue,
                             input logic [BYTES_W-1:0] bytes,
                             input logic typed, input t_verdict want);
        t_verdict calc;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_port <= port;
        i_queue <= queue;
        i_packet_bytes <= bytes;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        calc = predict_admission(op, port, queue, bytes);
        if (op == OP_ENQ && calc.admitted) held_pkts[{port, queue}].push_back(bytes);
        verdicts_due.push_back(typed ? want : calc);
        @(negedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input t_cnt value);
        case (idx)
            REG_POOL_LIMIT:  lim_pool = value;
            REG_PORT_LIMIT:  lim_port = value;
            REG_QSHARED_LIM: lim_qshared = value;
            REG_QGUARANTEE:  guar_bytes = value;
            REG_LOSSLESS:    lossless_on = value[0];
            REG_ALPHA:       alpha_q8 = value[ALPHA_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // mostly enqueues and matching dequeues of held packets, some stray dequeues
    task automatic run_phase(input t_cnt pool_v, port_v, qsh_v, guar_v,
                             input logic lossless_v, input logic [ALPHA_W-1:0] alpha_v,
                             input int idle_pct, input int words);
        int                        pick;
        int                        base;
        int                        probe;
        logic                      found;
        logic [PORT_W+QUEUE_W-1:0] slot;
        logic [PORT_W-1:0]         pt;
        logic [BYTES_W-1:0]        sz;
        wait_quiet();
        write_setting(REG_POOL_LIMIT, pool_v);
        write_setting(REG_PORT_LIMIT, port_v);
        write_setting(REG_QSHARED_LIM, qsh_v);
        write_setting(REG_QGUARANTEE, guar_v);
        write_setting(REG_LOSSLESS, {23'b0, lossless_v});
        write_setting(REG_ALPHA, {12'b0, alpha_v});
        sender_idle_pct = idle_pct;
        repeat (words) begin
            pick = $urandom_range(99);
            found = 1'b0;
            slot = '0;
            if (pick < 35) begin
                base = $urandom_range(SLOTS - 1);
                for (probe = 0; probe < SLOTS; probe++) begin
                    if (!found && held_pkts[(base + probe) % SLOTS].size() != 0) begin
                        found = 1'b1;
                        slot = 7'((base + probe) % SLOTS);
                    end
                end
            end
            case ($urandom_range(9)) inside
                [0:3]: sz = 16'($urandom_range(1500, 64));
                [4:7]: sz = 16'($urandom_range(65535));
                8: sz = ($urandom_range(1)) ? 16'hFFFF - 16'($urandom_range(1))
                                            : 16'($urandom_range(1));
                default: sz = 16'($urandom_range(63));
            endcase
            pt = ($urandom_range(99) < 60) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            if (found) begin
                send_word(OP_DEQ, slot[6:3], slot[2:0], held_pkts[slot].pop_front(),
                          1'b0, FROM_MODEL);
            end else if (pick < 90) begin
                send_word(OP_ENQ, pt, 3'($urandom_range(7)), sz, 1'b0, FROM_MODEL);
            end else begin
                send_word(OP_DEQ, pt, 3'($urandom_range(7)), sz, 1'b0, FROM_MODEL);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen.admitted = o_admitted;
            seen.reason = t_drop_reason'(o_drop_reason);
            seen.underflow = o_underflow;
            seen.port_now = o_port_bytes_now;
            seen.shared_now = o_queue_shared_now;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: adm=%0d drop=%0d uf=%0d port=%0d qsh=%0d",
                             seen.admitted, seen.reason, seen.underflow,
                             seen.port_now, seen.shared_now);
            end else begin
                due = verdicts_due.pop_front();
                if (seen !== due) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: want adm=%0d drop=%0d uf=%0d port=%0d qsh=%0d,",
                               due.admitted, due.reason, due.underflow,
                               due.port_now, due.shared_now);
                        $display(" got adm=%0d drop=%0d uf=%0d port=%0d qsh=%0d",
                                 seen.admitted, seen.reason, seen.underflow,
                                 seen.port_now, seen.shared_now);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("egress_buffer_admission_top_tb: errors");
            $finish;
        end
    end

    initial begin
        int r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        start = 1'b0;
        i_opcode = OP_ENQ;
        i_port = '0;
        i_queue = '0;
        i_packet_bytes = '0;
        mismatches = 0;
        cycles = 0;
        sender_idle_pct = 0;
        lim_pool = RST_POOL_LIMIT;
        lim_port = RST_PORT_LIMIT;
        lim_qshared = RST_QSHARED_LIM;
        guar_bytes = RST_QGUARANTEE;
        lossless_on = RST_LOSSLESS;
        alpha_q8 = RST_ALPHA;
        foreach (guar_cnt[k]) begin
            guar_cnt[k] = '0;
            shr_cnt[k] = '0;
        end
        foreach (port_cnt[k]) port_cnt[k] = '0;
        pool_cnt[0] = '0;
        pool_cnt[1] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].is_cfg) begin
                wait_quiet();
                write_setting(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                send_word(dir_rows[r].op, dir_rows[r].port, dir_rows[r].queue,
                          dir_rows[r].bytes, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        run_phase(RST_POOL_LIMIT, RST_PORT_LIMIT, RST_QSHARED_LIM, RST_QGUARANTEE,
                  1'b0, 12'd64, 0, 250);
        run_phase(24'd200000, 24'd150000, 24'd100000, 24'd1501, 1'b0, 12'd4095, 74, 250);
        run_phase(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 1'b1, 12'd0, 17, 200);
        run_phase(24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 12'd0, 0, 60);
        run_phase(24'd120000, 24'd90000, 24'd70000, 24'hFFFFFF, 1'b0, 12'd512, 74, 270);
        run_phase(24'd300000, 24'd100000, 24'd40000, 24'd3000, 1'b0, 12'd128, 17, 270);

        wait_quiet();
        if (mismatches == 0) begin
            $display("egress_buffer_admission_top_tb: clean");
        end else begin
            $display("egress_buffer_admission_top_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/eba_pkg.sv
rtl/core/egress_buffer_admission_top.sv
tb/egress_buffer_admission_top_tb.sv
